@@ rtl/srgp_pkg.sv @@
// Shared types and constants for the scaled, rotated glyph plotter.
// Used by every module of the block; depends on nothing.
`default_nettype none
package srgp_pkg;

	localparam int DEF_PANEL_WIDTH = 800;
	localparam int DEF_PANEL_HEIGHT = 480;
	localparam int DEF_MAX_SCALE = 8;

	localparam int VW = 18;
	localparam int MAG_W = 4;
	localparam int SUB_W = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGNIFICATION = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTATION = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INK_COLOR = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH = 3'd5;

	localparam logic [1:0] ROT_90 = 2'd1;
	localparam logic [1:0] ROT_270 = 2'd2;

	typedef struct packed {
		logic [11:0] origin_x;
		logic [11:0] origin_y;
		logic [MAG_W-1:0] magnification;
		logic [1:0] rotation;
		logic [3:0] ink_color;
		logic [5:0] glyph_width;
	} cfg_t;

	typedef struct packed {
		logic [VW-1:0] base_x;
		logic [VW-1:0] base_y;
		logic [MAG_W-1:0] mag;
	} block_t;

endpackage
`default_nettype wire

@@ rtl/srgp_front.sv @@
// Front end: accepts glyph pixels, drops empty ones and computes the block origin.
// Depends on srgp_pkg.
`default_nettype none
module srgp_front
	import srgp_pkg::*;
#(
	parameter int MAX_SCALE = DEF_MAX_SCALE
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire cfg_t cfg,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [5:0] char_pos,
	input wire logic [4:0] glyph_row,
	input wire logic [4:0] glyph_col,
	input wire logic pixel_filled,
	input wire logic q_full,
	output logic push,
	output block_t push_data
);

	logic en;
	logic [MAG_W-1:0] mag_eff;
	logic v_s1, v_s2;
	logic [11:0] pg_s1;
	logic [7:0] colm_s1, rowm_s1;
	logic [MAG_W-1:0] mag_s1, mag_s2;
	logic [VW-1:0] bx_s2, by_s2;
	logic [15:0] pgm;
	logic [VW-1:0] ox_ext, oy_ext;

	assign en = !(v_s2 && q_full);
	assign in_stall = !en;
	assign mag_eff = (cfg.magnification > MAG_W'(MAX_SCALE)) ? MAG_W'(MAX_SCALE)
		: cfg.magnification;
	assign pgm = 16'(pg_s1 * mag_s1);
	assign ox_ext = {{(VW-12){cfg.origin_x[11]}}, cfg.origin_x};
	assign oy_ext = {{(VW-12){cfg.origin_y[11]}}, cfg.origin_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid && pixel_filled && (mag_eff != '0);
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pg_s1 <= 12'(char_pos * cfg.glyph_width);
			colm_s1 <= 8'(glyph_col * mag_eff);
			rowm_s1 <= 8'(glyph_row * mag_eff);
			mag_s1 <= mag_eff;
			bx_s2 <= ox_ext + VW'(pgm) + VW'(colm_s1);
			by_s2 <= oy_ext + VW'(rowm_s1);
			mag_s2 <= mag_s1;
		end
	end

	assign push = v_s2 && en;
	assign push_data = '{base_x: bx_s2, base_y: by_s2, mag: mag_s2};

endmodule
`default_nettype wire

@@ rtl/srgp_queue.sv @@
// Short queue of pending blocks between the front and back ends.
// Depends on srgp_pkg.
`default_nettype none
module srgp_queue
	import srgp_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire block_t push_data,
	input wire logic pop,
	output logic full,
	output logic empty,
	output block_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	block_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

@@ rtl/srgp_back.sv @@
// Back end: walks each block one write a cycle unless out_stall holds it, rotates and forms the buffer address.
// Depends on srgp_pkg.
`default_nettype none
module srgp_back
	import srgp_pkg::*;
#(
	parameter int PANEL_WIDTH = DEF_PANEL_WIDTH,
	parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire cfg_t cfg,
	input wire logic q_empty,
	input wire block_t q_head,
	output logic pop,
	output logic out_valid,
	input wire logic out_stall,
	output logic [17:0] byte_address,
	output logic high_nibble,
	output logic [3:0] pixel_color,
	output logic in_panel,
	output logic last
);

	localparam int PW_W = $clog2(PANEL_WIDTH + 1);
	localparam int LIN_RAW = 12 + PW_W + 1;
	localparam int LIN_W = (LIN_RAW > 19) ? LIN_RAW : 19;
	localparam logic [VW-1:0] PW_V = VW'(PANEL_WIDTH);
	localparam logic [VW-1:0] PH_V = VW'(PANEL_HEIGHT);

	logic en;
	logic busy_q;
	logic [VW-1:0] bx_q, by_q;
	logic [MAG_W-1:0] mag_q;
	logic [SUB_W-1:0] sx_q, sy_q;
	logic row_end, blk_end, load;
	logic [VW-1:0] vx, vy, nx, ny;
	logic v_s1, last_s1;
	logic [VW-1:0] nx_s1, ny_s1;
	logic on_panel;
	logic [LIN_W-1:0] lin;

	assign en = !(out_valid && out_stall);
	assign row_end = (MAG_W'(sx_q) == mag_q - 1'b1);
	assign blk_end = row_end && (MAG_W'(sy_q) == mag_q - 1'b1);
	assign load = en && (!busy_q || blk_end) && !q_empty;
	assign pop = load;

	assign vx = bx_q + VW'(sx_q);
	assign vy = by_q + VW'(sy_q);

	always_comb begin
		priority if (cfg.rotation == ROT_90) begin
			nx = PW_V - 1'b1 - vy;
			ny = vx;
		end else if (cfg.rotation == ROT_270) begin
			nx = vy;
			ny = PH_V - 1'b1 - vx;
		end else begin
			nx = vx;
			ny = vy;
		end
	end

	assign on_panel = !nx_s1[VW-1] && ($signed(nx_s1) < $signed(PW_V))
		&& !ny_s1[VW-1] && ($signed(ny_s1) < $signed(PH_V));
	assign lin = LIN_W'(ny_s1[11:0]) * LIN_W'(PANEL_WIDTH) + LIN_W'(nx_s1[11:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sx_q <= '0;
			sy_q <= '0;
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= busy_q;
			out_valid <= v_s1;
			if (load) begin
				busy_q <= 1'b1;
				sx_q <= '0;
				sy_q <= '0;
			end else if (busy_q) begin
				if (blk_end) begin
					busy_q <= 1'b0;
				end else if (row_end) begin
					sx_q <= '0;
					sy_q <= sy_q + 1'b1;
				end else begin
					sx_q <= sx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bx_q <= q_head.base_x;
			by_q <= q_head.base_y;
			mag_q <= q_head.mag;
		end
		if (en) begin
			nx_s1 <= nx;
			ny_s1 <= ny;
			last_s1 <= blk_end;
			byte_address <= on_panel ? lin[18:1] : '0;
			high_nibble <= on_panel && !nx_s1[0];
			in_panel <= on_panel;
			pixel_color <= cfg.ink_color;
			last <= last_s1;
		end
	end

endmodule
`default_nettype wire

@@ rtl/scaled_rotated_glyph_plotter.sv @@
// Top level of the scaled, rotated glyph plotter: configuration registers and wiring.
// Depends on srgp_pkg, srgp_front, srgp_queue and srgp_back.
//
// Input beats carry one glyph pixel on char_pos, glyph_row, glyph_col and
// pixel_filled under in_valid and in_stall. An unfilled pixel, or any pixel
// while the magnification is zero, yields no output. A filled pixel yields
// mag x mag output beats, row by row, each a nibble write with its byte
// address, nibble select, color, in-panel flag and a last flag on the final one.
// Magnification above MAX_SCALE is treated as MAX_SCALE.
// A block passes from the front end through the queue to the back end, which walks it.
// The back end emits one write per cycle unless out_stall holds it, mag x mag
// writes for a filled pixel; the front end takes one input beat per cycle while
// in_stall is low and parks up to four blocks in a queue while the back end is busy.
// When out_stall is high with out_valid set, the output beat holds and the back
// end freezes; once the queue is full and a further block waits to enter it, in_stall rises.
// Reset empties the pipeline and queue and loads the default register values.
// Registers are written through cfg_wr_en, cfg_index and cfg_data; the user must
// write them only while the block is idle, which the block itself does not enforce.
`default_nettype none
module scaled_rotated_glyph_plotter
	import srgp_pkg::*;
#(
	parameter int PANEL_WIDTH = DEF_PANEL_WIDTH,
	parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT,
	parameter int MAX_SCALE = DEF_MAX_SCALE
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [5:0] char_pos,
	input wire logic [4:0] glyph_row,
	input wire logic [4:0] glyph_col,
	input wire logic pixel_filled,
	output logic out_valid,
	input wire logic out_stall,
	output logic [17:0] byte_address,
	output logic high_nibble,
	output logic [3:0] pixel_color,
	output logic in_panel,
	output logic last
);

	cfg_t cfg_q;
	logic push, pop, q_full, q_empty;
	block_t push_data, q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{origin_x: 12'd0, origin_y: 12'd0, magnification: 4'd1,
				rotation: 2'd0, ink_color: 4'd1, glyph_width: 6'd17};
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_ORIGIN_X: cfg_q.origin_x <= cfg_data[11:0];
				CFG_ORIGIN_Y: cfg_q.origin_y <= cfg_data[11:0];
				CFG_MAGNIFICATION: cfg_q.magnification <= cfg_data[3:0];
				CFG_ROTATION: cfg_q.rotation <= cfg_data[1:0];
				CFG_INK_COLOR: cfg_q.ink_color <= cfg_data[3:0];
				CFG_GLYPH_WIDTH: cfg_q.glyph_width <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	srgp_front #(
		.MAX_SCALE(MAX_SCALE)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_pos(char_pos),
		.glyph_row(glyph_row),
		.glyph_col(glyph_col),
		.pixel_filled(pixel_filled),
		.q_full(q_full),
		.push(push),
		.push_data(push_data)
	);

	srgp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.full(q_full),
		.empty(q_empty),
		.head(q_head)
	);

	srgp_back #(
		.PANEL_WIDTH(PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_empty(q_empty),
		.q_head(q_head),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.byte_address(byte_address),
		.high_nibble(high_nibble),
		.pixel_color(pixel_color),
		.in_panel(in_panel),
		.last(last)
	);

endmodule
`default_nettype wire
